>>> sv/listener_slot_table_macros.svh
// ---------------------------------------------------------------------------
// listener_slot_table_macros.svh
// Assertion helpers for the listener slot table.
// ---------------------------------------------------------------------------
`ifndef LISTENER_SLOT_TABLE_MACROS_SVH
`define LISTENER_SLOT_TABLE_MACROS_SVH

`ifndef SYNTHESIS
// Property must hold at every edge outside reset.
`define LST_ASSERT(lbl, clk, rstn, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) prop) else $error(msg);
// Expression must never be true outside reset.
`define LST_NEVER(lbl, clk, rstn, expr, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) !(expr)) else $error(msg);
`else
`define LST_ASSERT(lbl, clk, rstn, prop, msg)
`define LST_NEVER(lbl, clk, rstn, expr, msg)
`endif

`endif

>>> sv/lst_pkg.sv
// ---------------------------------------------------------------------------
// lst_pkg
// Shared types and constants of the listener slot table.
// ---------------------------------------------------------------------------
package lst_pkg;

  localparam int ENT_W  = 12;
  localparam int POS_W  = 24;
  localparam int SLOT_W = 4;
  localparam int MAG_W  = 24;  // |a - b| of two 24-bit signed values
  localparam int SQ_W   = 48;
  localparam int SUM_W  = 50;  // three squares stay below 2^50
  localparam int DIST_W = 52;

  localparam logic [DIST_W-1:0] DIST_NONE = '1;

  typedef enum logic [1:0] {
    CMD_UPDATE    = 2'd0,
    CMD_END_FRAME = 2'd1,
    CMD_LOOKUP    = 2'd2,
    CMD_CLOSEST   = 2'd3
  } lst_cmd_e;

  // One stored slot
  typedef struct packed {
    logic [ENT_W-1:0] entity;
    logic [POS_W-1:0] pos_x;
    logic [POS_W-1:0] pos_y;
    logic [POS_W-1:0] pos_z;
    logic             fp;
  } lst_entry_t;

  // Entity compare result for one slot
  typedef struct packed {
    logic              vld;
    logic [SLOT_W-1:0] idx;
    logic              hit;
    logic              fp;
  } lst_hit_t;

  // Squared distance result for one slot
  typedef struct packed {
    logic              vld;
    logic [SLOT_W-1:0] idx;
    logic              slot_vld;
    logic [SUM_W-1:0]  dsq;
  } lst_dist_t;

endpackage

>>> sv/lst_slot_mem.sv
// ---------------------------------------------------------------------------
// lst_slot_mem
// Slot payload memory: one write port, one read port, registered read data.
// ---------------------------------------------------------------------------
module lst_slot_mem
  import lst_pkg::*;
#(
  parameter int DEPTH = 4,
  parameter int AW    = 2
) (
  input  logic          clk_i,
  input  logic          we_i,
  input  logic [AW-1:0] waddr_i,
  input  lst_entry_t    wdata_i,
  input  logic          re_i,
  input  logic [AW-1:0] raddr_i,
  output lst_entry_t    rdata_o
);

  lst_entry_t mem [DEPTH];
  lst_entry_t rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

>>> sv/lst_dist_pipe.sv
// ---------------------------------------------------------------------------
// lst_dist_pipe
// Per-slot compare pipeline: entity match, axis deltas, squares, sum.
// ---------------------------------------------------------------------------
module lst_dist_pipe
  import lst_pkg::*;
#(
  parameter int NUM_SLOTS = 4,
  parameter int IDX_W     = 2
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 rd_en_i,
  input  logic [IDX_W-1:0]     rd_idx_i,
  input  lst_entry_t           rdata_i,
  input  logic [NUM_SLOTS-1:0] slot_valid_i,
  input  logic [ENT_W-1:0]     q_entity_i,
  input  logic [POS_W-1:0]     q_x_i,
  input  logic [POS_W-1:0]     q_y_i,
  input  logic [POS_W-1:0]     q_z_i,
  output lst_hit_t             hit_o,
  output lst_dist_t            dist_o,
  output logic                 busy_o
);

  function automatic logic [MAG_W-1:0] abs_diff(logic [POS_W-1:0] a, logic [POS_W-1:0] b);
    logic signed [POS_W:0] d;
    d = $signed({a[POS_W-1], a}) - $signed({b[POS_W-1], b});
    if (d[POS_W]) d = -d;
    return d[MAG_W-1:0];
  endfunction

  // stage valids
  logic s1_vld_q, s2_vld_q, s3_vld_q, s4_vld_q;
  // stage payloads
  logic [IDX_W-1:0] s1_idx_q, s2_idx_q, s3_idx_q, s4_idx_q;
  logic             s2_hit_q, s2_fp_q, s2_sv_q, s3_sv_q, s4_sv_q;
  logic [MAG_W-1:0] s2_mx_q, s2_my_q, s2_mz_q;
  logic [SQ_W-1:0]  s3_sx_q, s3_sy_q, s3_sz_q;
  logic [SUM_W-1:0] s4_dist_q;
  logic             s1_sv;

  assign s1_sv = slot_valid_i[s1_idx_q];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_vld_q <= 1'b0;
      s2_vld_q <= 1'b0;
      s3_vld_q <= 1'b0;
      s4_vld_q <= 1'b0;
    end else begin
      s1_vld_q <= rd_en_i;
      s2_vld_q <= s1_vld_q;
      s3_vld_q <= s2_vld_q;
      s4_vld_q <= s3_vld_q;
    end
  end

  always_ff @(posedge clk_i) begin
    s1_idx_q  <= rd_idx_i;
    s2_idx_q  <= s1_idx_q;
    s2_sv_q   <= s1_sv;
    s2_hit_q  <= s1_sv && (rdata_i.entity == q_entity_i);
    s2_fp_q   <= rdata_i.fp;
    s2_mx_q   <= abs_diff(q_x_i, rdata_i.pos_x);
    s2_my_q   <= abs_diff(q_y_i, rdata_i.pos_y);
    s2_mz_q   <= abs_diff(q_z_i, rdata_i.pos_z);
    s3_idx_q  <= s2_idx_q;
    s3_sv_q   <= s2_sv_q;
    s3_sx_q   <= s2_mx_q * s2_mx_q;
    s3_sy_q   <= s2_my_q * s2_my_q;
    s3_sz_q   <= s2_mz_q * s2_mz_q;
    s4_idx_q  <= s3_idx_q;
    s4_sv_q   <= s3_sv_q;
    s4_dist_q <= SUM_W'(s3_sx_q) + SUM_W'(s3_sy_q) + SUM_W'(s3_sz_q);
  end

  assign hit_o.vld  = s2_vld_q;
  assign hit_o.idx  = SLOT_W'(s2_idx_q);
  assign hit_o.hit  = s2_hit_q;
  assign hit_o.fp   = s2_fp_q;

  assign dist_o.vld      = s4_vld_q;
  assign dist_o.idx      = SLOT_W'(s4_idx_q);
  assign dist_o.slot_vld = s4_sv_q;
  assign dist_o.dsq      = s4_dist_q;

  assign busy_o = s1_vld_q | s2_vld_q | s3_vld_q | s4_vld_q;

endmodule

>>> sv/listener_slot_table.sv
// ---------------------------------------------------------------------------
// listener_slot_table
// Table of listener slots with update, end-of-frame, lookup and closest.
// ---------------------------------------------------------------------------
// Usage:
//   Commands come in on the input channel (in_valid_i / in_stall_o); each
//   command gives exactly one result on the output channel (out_valid_o /
//   out_stall_i). One command is worked on at a time; in_stall_o is high
//   from the transfer until the command has finished.
//   Update, lookup and closest scan every slot through the slot memory, one
//   read per cycle, followed by a four-stage compare pipeline. The next
//   command can be taken in the cycle in which such a command's result
//   appears. End frame touches only the valid and updated flags and skips
//   the scan.
//   The result sits in an output register: a finished command leaves the
//   engine free, so the next command is taken while the result is stalled;
//   that command then waits to finish until the register is drained.
//   Reset clears all valid and updated flags at once; the slot memory
//   itself needs no clearing since only valid slots are ever used.
//   An update whose slot is chosen is written back in its final cycle, before
//   the next command can read, so no forwarding is needed.
// ---------------------------------------------------------------------------
`include "listener_slot_table_macros.svh"

module listener_slot_table
  import lst_pkg::*;
#(
  parameter int NUM_SLOTS = 4
) (
  input  logic                     clk_i,
  input  logic                     rst_ni,
  input  logic                     in_valid_i,
  output logic                     in_stall_o,
  input  logic [1:0]               cmd_i,
  input  logic [ENT_W-1:0]         entity_i,
  input  logic signed [POS_W-1:0]  pos_x_i,
  input  logic signed [POS_W-1:0]  pos_y_i,
  input  logic signed [POS_W-1:0]  pos_z_i,
  input  logic                     first_person_i,
  output logic                     out_valid_o,
  input  logic                     out_stall_i,
  output logic                     found_o,
  output logic [SLOT_W-1:0]        slot_o,
  output logic                     hears_first_person_o,
  output logic [DIST_W-1:0]        distance_sq_o
);

  localparam int IDX_W = (NUM_SLOTS > 1) ? $clog2(NUM_SLOTS) : 1;
  localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(NUM_SLOTS - 1);

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_SCAN,
    ST_FIN
  } state_e;

  state_e state_q;

  // Command under work
  lst_cmd_e         q_cmd_q;
  logic [ENT_W-1:0] q_ent_q;
  logic [POS_W-1:0] q_x_q, q_y_q, q_z_q;
  logic             q_fp_q;

  // Slot flags live in flops
  logic [NUM_SLOTS-1:0] slot_valid_q, slot_upd_q;

  // Read sequencer
  logic [IDX_W-1:0] rd_idx_q;
  logic             issue_done_q;
  logic             rd_en;

  // Scan accumulators
  logic              hit_found_q, hit_fp_q;
  logic [SLOT_W-1:0] hit_idx_q;
  logic              best_found_q;
  logic [SLOT_W-1:0] best_idx_q;
  logic [SUM_W-1:0]  best_dist_q;

  // Output register
  logic              out_vld_q, out_found_q, out_hears_q;
  logic [SLOT_W-1:0] out_slot_q;
  logic [DIST_W-1:0] out_dist_q;

  lst_entry_t rdata, wdata;
  lst_hit_t   hit;
  lst_dist_t  dist_res;
  logic       pipe_busy;

  logic             in_xfer, fin_go, mem_we;
  logic             free_ok, victim_ok, pick_ok;
  logic [IDX_W-1:0] free_idx, victim_idx, pick_idx;

  logic              res_found, res_hears;
  logic [SLOT_W-1:0] res_slot;
  logic [DIST_W-1:0] res_dist;

  assign in_stall_o = (state_q != ST_IDLE);
  assign in_xfer    = in_valid_i && !in_stall_o;
  assign rd_en      = (state_q == ST_SCAN) && !issue_done_q;
  assign fin_go     = (state_q == ST_FIN) && (!out_vld_q || !out_stall_i);

  // --- Slot choice for update --------------------------------------------
  always_comb begin
    free_ok    = 1'b0;
    free_idx   = '0;
    victim_ok  = 1'b0;
    victim_idx = '0;
    // lowest invalid slot
    for (int i = NUM_SLOTS - 1; i >= 0; i--) begin
      if (!slot_valid_q[i]) begin
        free_ok  = 1'b1;
        free_idx = IDX_W'(i);
      end
    end
    // highest valid slot not refreshed this frame
    for (int i = 0; i < NUM_SLOTS; i++) begin
      if (slot_valid_q[i] && !slot_upd_q[i]) begin
        victim_ok  = 1'b1;
        victim_idx = IDX_W'(i);
      end
    end
  end

  always_comb begin
    if (hit_found_q) begin
      pick_idx = hit_idx_q[IDX_W-1:0];
    end else if (free_ok) begin
      pick_idx = free_idx;
    end else begin
      pick_idx = victim_idx;
    end
  end

  assign pick_ok = hit_found_q || free_ok || victim_ok;
  assign mem_we  = fin_go && (q_cmd_q == CMD_UPDATE) && pick_ok;

  assign wdata.entity = q_ent_q;
  assign wdata.pos_x  = q_x_q;
  assign wdata.pos_y  = q_y_q;
  assign wdata.pos_z  = q_z_q;
  assign wdata.fp     = q_fp_q;

  // --- Result per command ------------------------------------------------
  always_comb begin
    res_found = 1'b0;
    res_slot  = '0;
    res_hears = 1'b0;
    res_dist  = '0;
    unique case (q_cmd_q)
      CMD_UPDATE: begin
        res_found = pick_ok;
        res_slot  = pick_ok ? SLOT_W'(pick_idx) : '0;
      end
      CMD_END_FRAME: begin
      end
      CMD_LOOKUP: begin
        res_found = hit_found_q;
        res_slot  = hit_found_q ? hit_idx_q : '0;
        res_hears = hit_found_q && hit_fp_q;
      end
      CMD_CLOSEST: begin
        res_found = best_found_q;
        res_slot  = best_found_q ? best_idx_q : '0;
        res_dist  = best_found_q ? DIST_W'(best_dist_q) : DIST_NONE;
      end
      default: begin
      end
    endcase
  end

  // --- Sequencer ---------------------------------------------------------
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q      <= ST_IDLE;
      rd_idx_q     <= '0;
      issue_done_q <= 1'b0;
      slot_valid_q <= '0;
      slot_upd_q   <= '0;
    end else begin
      unique case (state_q)
        ST_IDLE: begin
          if (in_xfer) begin
            rd_idx_q     <= '0;
            issue_done_q <= 1'b0;
            state_q      <= (lst_cmd_e'(cmd_i) == CMD_END_FRAME) ? ST_FIN : ST_SCAN;
          end
        end
        ST_SCAN: begin
          if (!issue_done_q) begin
            if (rd_idx_q == LAST_IDX) begin
              issue_done_q <= 1'b1;
            end else begin
              rd_idx_q <= rd_idx_q + 1'b1;
            end
          end else if (!pipe_busy) begin
            state_q <= ST_FIN;
          end
        end
        ST_FIN: begin
          if (fin_go) begin
            state_q   <= ST_IDLE;
            if (q_cmd_q == CMD_END_FRAME) begin
              slot_valid_q <= slot_valid_q & slot_upd_q;
              slot_upd_q   <= '0;
            end
            if (mem_we) begin
              slot_valid_q[pick_idx] <= 1'b1;
              slot_upd_q[pick_idx]   <= 1'b1;
            end
          end
        end
        default: state_q <= ST_IDLE;
      endcase
    end
  end

  // Result valid: set by a finishing command, cleared once drained
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_vld_q <= 1'b0;
    end else if (fin_go) begin
      out_vld_q <= 1'b1;
    end else if (out_vld_q && !out_stall_i) begin
      out_vld_q <= 1'b0;
    end
  end

  // Command capture, scan accumulators and result payload
  always_ff @(posedge clk_i) begin
    if (in_xfer) begin
      q_cmd_q      <= lst_cmd_e'(cmd_i);
      q_ent_q      <= entity_i;
      q_x_q        <= pos_x_i;
      q_y_q        <= pos_y_i;
      q_z_q        <= pos_z_i;
      q_fp_q       <= first_person_i;
      hit_found_q  <= 1'b0;
      best_found_q <= 1'b0;
    end else begin
      // first matching slot in index order
      if (hit.vld && hit.hit && !hit_found_q) begin
        hit_found_q <= 1'b1;
        hit_idx_q   <= hit.idx;
        hit_fp_q    <= hit.fp;
      end
      // strict compare keeps the lower index on ties
      if (dist_res.vld && dist_res.slot_vld &&
          (!best_found_q || dist_res.dsq < best_dist_q)) begin
        best_found_q <= 1'b1;
        best_idx_q   <= dist_res.idx;
        best_dist_q  <= dist_res.dsq;
      end
    end
    if (fin_go) begin
      out_found_q <= res_found;
      out_slot_q  <= res_slot;
      out_hears_q <= res_hears;
      out_dist_q  <= res_dist;
    end
  end

  lst_slot_mem #(
    .DEPTH (NUM_SLOTS),
    .AW    (IDX_W)
  ) u_mem (
    .clk_i   (clk_i),
    .we_i    (mem_we),
    .waddr_i (pick_idx),
    .wdata_i (wdata),
    .re_i    (rd_en),
    .raddr_i (rd_idx_q),
    .rdata_o (rdata)
  );

  lst_dist_pipe #(
    .NUM_SLOTS (NUM_SLOTS),
    .IDX_W     (IDX_W)
  ) u_pipe (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .rd_en_i      (rd_en),
    .rd_idx_i     (rd_idx_q),
    .rdata_i      (rdata),
    .slot_valid_i (slot_valid_q),
    .q_entity_i   (q_ent_q),
    .q_x_i        (q_x_q),
    .q_y_i        (q_y_q),
    .q_z_i        (q_z_q),
    .hit_o        (hit),
    .dist_o       (dist_res),
    .busy_o       (pipe_busy)
  );

  assign out_valid_o          = out_vld_q;
  assign found_o              = out_found_q;
  assign slot_o               = out_slot_q;
  assign hears_first_person_o = out_hears_q;
  assign distance_sq_o        = out_dist_q;

  // --- Checks ------------------------------------------------------------
  `LST_NEVER(a_upd_implies_valid, clk_i, rst_ni, |(slot_upd_q & ~slot_valid_q), "upd w/o valid")
  `LST_NEVER(a_idle_pipe_empty, clk_i, rst_ni, (state_q == ST_IDLE) && pipe_busy, "busy idle")
  `LST_ASSERT(a_wr_valid, clk_i, rst_ni, mem_we |=> slot_valid_q[$past(pick_idx)], "write lost")
  `LST_ASSERT(a_busy_after_xfer, clk_i, rst_ni, in_xfer |=> in_stall_o, "input taken twice")

endmodule
